### src/mmn_pkg.sv
// ----------------------------------------------------------------------------
// mmn_pkg: shared types and constants of the min-max normalizer
// Widths, request and register codes, sequencer states and the control and
// status bundles between the core and its multiply/divide unit.
// ----------------------------------------------------------------------------
package mmn_pkg;

    // Q16.16 sample width and derived arithmetic widths
    localparam int DATA_W  = 32;
    localparam int SPAN_W  = DATA_W + 1;      // difference of two samples
    localparam int OFF_W   = DATA_W + 2;      // offset added after the divide
    localparam int ACC_W   = 49;              // signed quotient or h*h >> 16
    localparam int SUM_W   = 50;              // accumulator plus offset
    localparam int PROD_W  = 2 * DATA_W;
    localparam int QUOT_W  = DATA_W + 1;      // quotient, capped at 2^32
    localparam int FRAC_W  = 16;

    // Stream and configuration port widths
    localparam int S_TDATA_W = 72;            // value, value_high, restart
    localparam int S_TUSER_W = 2;             // req_type
    localparam int M_TDATA_W = 104;           // result, flags, bounds
    localparam int CFG_IDX_W = 1;

    // Divide sequencing
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Reset values and fixed constants
    localparam logic signed [DATA_W-1:0] TARGET_LOW_RST  = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] TARGET_HIGH_RST = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] SEEN_LOW_RST    = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] SEEN_HIGH_RST   = 32'sh0001_0000;
    localparam logic signed [OFF_W-1:0]  Q_ONE_OFF       = 34'sh0_0001_0000;
    localparam logic [QUOT_W-1:0]        QUOT_CAP        = 33'h1_0000_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX         = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN         = 32'sh8000_0000;

    // Request kinds carried on the input tuser
    typedef enum logic [S_TUSER_W-1:0] {
        REQ_OBSERVE = 2'd0,
        REQ_FORWARD = 2'd1,
        REQ_MAPBACK = 2'd2,
        REQ_LOAD    = 2'd3
    } t_req;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_LOW  = 1'b0,
        REG_TARGET_HIGH = 1'b1
    } t_cfg_reg;

    // Core sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_LAUNCH,
        ST_REPAIR,
        ST_WAIT,
        ST_SUM,
        ST_RANGE,
        ST_OUT
    } t_state;

    // Multiply/divide unit sequencer
    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_DONE
    } t_md_state;

    // Command to the multiply/divide unit
    typedef struct packed {
        logic              start;
        logic              mul_only;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] divisor;
    } t_md_cmd;

    // Status from the multiply/divide unit
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [PROD_W-1:0] prod;
    } t_md_sts;

endpackage

### src/mmn_muldiv.sv
// ----------------------------------------------------------------------------
// mmn_muldiv: unsigned multiply then radix-2 restoring divide
// One 32x32 multiply, then one shared 34-bit subtractor checks quotient
// overflow and performs 32 quotient steps. The quotient is capped at 2^32.
// ----------------------------------------------------------------------------
module mmn_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmn_pkg::t_md_cmd i_cmd,
    output mmn_pkg::t_md_sts o_sts
);

    mmn_pkg::t_md_state r_state, n_state;

    logic                        r_mul_only, n_mul_only;
    logic [mmn_pkg::DATA_W-1:0]  r_a, n_a;
    logic [mmn_pkg::DATA_W-1:0]  r_b, n_b;
    logic [mmn_pkg::DATA_W-1:0]  r_d, n_d;
    logic [mmn_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [mmn_pkg::DATA_W-1:0]  r_rem, n_rem;
    logic [mmn_pkg::DATA_W-1:0]  r_quo, n_quo;
    logic                        r_ovf, n_ovf;
    logic [mmn_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    logic [mmn_pkg::DATA_W:0]    sub_x;
    logic [mmn_pkg::DATA_W+1:0]  sub_diff;
    logic                        sub_ge;

    // Shared subtractor: overflow check, then one quotient bit per step
    always_comb begin
        if (r_state == mmn_pkg::MD_CHK) begin
            sub_x = {1'b0, r_prod[mmn_pkg::PROD_W-1:mmn_pkg::DATA_W]};
        end else begin
            sub_x = {r_rem, r_quo[mmn_pkg::DATA_W-1]};
        end
        sub_diff = {1'b0, sub_x} - {2'b00, r_d};
        sub_ge   = !sub_diff[mmn_pkg::DATA_W+1];
    end

    // Sequencer and datapath next values
    always_comb begin
        n_state    = r_state;
        n_mul_only = r_mul_only;
        n_a        = r_a;
        n_b        = r_b;
        n_d        = r_d;
        n_prod     = r_prod;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_ovf      = r_ovf;
        n_cnt      = r_cnt;
        unique case (r_state)
            mmn_pkg::MD_IDLE: begin
                if (i_cmd.start) begin
                    n_mul_only = i_cmd.mul_only;
                    n_a        = i_cmd.mag_a;
                    n_b        = i_cmd.mag_b;
                    n_d        = i_cmd.divisor;
                    n_state    = mmn_pkg::MD_MUL;
                end
            end
            mmn_pkg::MD_MUL: begin
                n_prod  = r_a * r_b;
                n_state = mmn_pkg::MD_CHK;
            end
            mmn_pkg::MD_CHK: begin
                n_rem = r_prod[mmn_pkg::PROD_W-1:mmn_pkg::DATA_W];
                n_quo = r_prod[mmn_pkg::DATA_W-1:0];
                n_cnt = '0;
                n_ovf = sub_ge;
                priority if (r_mul_only || sub_ge) begin
                    n_state = mmn_pkg::MD_DONE;
                end else begin
                    n_state = mmn_pkg::MD_DIV;
                end
            end
            mmn_pkg::MD_DIV: begin
                // Shift the next dividend bit in, keep the difference if it fits
                n_rem = sub_ge ? sub_diff[mmn_pkg::DATA_W-1:0]
                               : sub_x[mmn_pkg::DATA_W-1:0];
                n_quo = {r_quo[mmn_pkg::DATA_W-2:0], sub_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mmn_pkg::CNT_W'(mmn_pkg::DIV_STEPS - 1)) begin
                    n_state = mmn_pkg::MD_DONE;
                end
            end
            mmn_pkg::MD_DONE: begin
                n_state = mmn_pkg::MD_IDLE;
            end
            default: begin
                n_state = mmn_pkg::MD_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmn_pkg::MD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operands and working registers
    always_ff @(posedge i_clk) begin
        r_mul_only <= n_mul_only;
        r_a        <= n_a;
        r_b        <= n_b;
        r_d        <= n_d;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_ovf      <= n_ovf;
        r_cnt      <= n_cnt;
    end

    assign o_sts.done = (r_state == mmn_pkg::MD_DONE);
    assign o_sts.quot = r_ovf ? mmn_pkg::QUOT_CAP : {1'b0, r_quo};
    assign o_sts.prod = r_prod;

endmodule

### src/min_max_normalizer_core.sv
// ----------------------------------------------------------------------------
// min_max_normalizer_core: running min/max tracker and Q16.16 range scaler
// Observes samples, scales into the target range, maps back, loads bounds.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser: req_type; tdata: value, value_high, restart;
//                       tlast: last_of_batch
//  m_axis    out        tdata: result, saturated, zero_span, out_of_target,
//                       bound_low, bound_high
//  cfg       in         i_cfg_index selects target_low/target_high, i_cfg_data
//
//  Scale and map-back items run the 32-step divide in the shared
//  multiply/divide unit, whose divide steps are skipped when the quotient
//  overflows. Observe items use the unit only when the equal-bounds
//  repair multiplies. Load and zero-span items bypass the unit.
//  One item at a time: s_axis_tready is low until the result is transferred.
//  Reset (synchronous, active low) restores target and tracked bounds.
// ----------------------------------------------------------------------------
module min_max_normalizer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mmn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mmn_pkg::DATA_W-1:0]        i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] value, [63:32] value_high, [64] restart, [71:65] zero
    input  logic [mmn_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [mmn_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    input  logic                              s_axis_tlast,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] result, [32] saturated, [33] zero_span, [34] out_of_target,
    // [66:35] bound_low, [98:67] bound_high, [103:99] zero
    output logic [mmn_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    localparam int DW = mmn_pkg::DATA_W;

    mmn_pkg::t_state r_state, n_state;

    // Configuration and tracked bounds
    logic signed [DW-1:0] r_tlow, n_tlow;
    logic signed [DW-1:0] r_thigh, n_thigh;
    logic signed [DW-1:0] r_seen_low, n_seen_low;
    logic signed [DW-1:0] r_seen_high, n_seen_high;

    // Captured item
    mmn_pkg::t_req        r_req, n_req;
    logic signed [DW-1:0] r_val, n_val;
    logic signed [DW-1:0] r_valh, n_valh;
    logic                 r_restart, n_restart;
    logic                 r_last, n_last;

    // Working registers
    logic signed [mmn_pkg::SPAN_W-1:0] r_a, n_a;
    logic signed [mmn_pkg::SPAN_W-1:0] r_b, n_b;
    logic signed [mmn_pkg::SPAN_W-1:0] r_span, n_span;
    logic signed [mmn_pkg::OFF_W-1:0]  r_off, n_off;
    logic signed [mmn_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic                              r_neg, n_neg;
    logic                              r_repair, n_repair;

    // Unit command
    logic                 r_md_start, n_md_start;
    logic                 r_mul_only, n_mul_only;
    logic [DW-1:0]        r_mag_a, n_mag_a;
    logic [DW-1:0]        r_mag_b, n_mag_b;
    logic [DW-1:0]        r_div, n_div;

    // Result
    logic signed [DW-1:0] r_res, n_res;
    logic                 r_sat, n_sat;
    logic                 r_zspan, n_zspan;
    logic                 r_oot, n_oot;

    mmn_pkg::t_md_cmd md_cmd;
    mmn_pkg::t_md_sts md_sts;

    logic                              in_xfer;
    logic signed [mmn_pkg::SPAN_W-1:0] a_abs, b_abs, h_ext, h_abs;
    logic signed [mmn_pkg::ACC_W-1:0]  q_ext;
    logic signed [mmn_pkg::SUM_W-1:0]  sum;
    logic                              sum_pos_ovf, sum_neg_ovf;
    logic signed [DW-1:0]              sum_sat;

    assign o_cfg_ready   = (r_state == mmn_pkg::ST_IDLE);
    assign s_axis_tready = (r_state == mmn_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == mmn_pkg::ST_OUT);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = {5'b00000, r_seen_high, r_seen_low,
                            r_oot, r_zspan, r_sat, r_res};

    // Shared multiply/divide unit
    assign md_cmd.start    = r_md_start;
    assign md_cmd.mul_only = r_mul_only;
    assign md_cmd.mag_a    = r_mag_a;
    assign md_cmd.mag_b    = r_mag_b;
    assign md_cmd.divisor  = r_div;

    mmn_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (md_cmd),
        .o_sts   (md_sts)
    );

    // Magnitudes, signed quotient and saturating final add
    always_comb begin
        a_abs = r_a[mmn_pkg::SPAN_W-1] ? -r_a : r_a;
        b_abs = r_b[mmn_pkg::SPAN_W-1] ? -r_b : r_b;
        h_ext = mmn_pkg::SPAN_W'(r_seen_high);
        h_abs = h_ext[mmn_pkg::SPAN_W-1] ? -h_ext : h_ext;
        q_ext = $signed({16'h0000, md_sts.quot});
        sum   = mmn_pkg::SUM_W'(r_acc) + mmn_pkg::SUM_W'(r_off);
        sum_pos_ovf = !sum[mmn_pkg::SUM_W-1] && (|sum[mmn_pkg::SUM_W-2:DW-1]);
        sum_neg_ovf = sum[mmn_pkg::SUM_W-1] && !(&sum[mmn_pkg::SUM_W-2:DW-1]);
        priority if (sum_pos_ovf) begin
            sum_sat = mmn_pkg::SAT_MAX;
        end else if (sum_neg_ovf) begin
            sum_sat = mmn_pkg::SAT_MIN;
        end else begin
            sum_sat = sum[DW-1:0];
        end
    end

    // Sequencer and register next values
    always_comb begin
        n_state     = r_state;
        n_tlow      = r_tlow;
        n_thigh     = r_thigh;
        n_seen_low  = r_seen_low;
        n_seen_high = r_seen_high;
        n_req       = r_req;
        n_val       = r_val;
        n_valh      = r_valh;
        n_restart   = r_restart;
        n_last      = r_last;
        n_a         = r_a;
        n_b         = r_b;
        n_span      = r_span;
        n_off       = r_off;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_repair    = r_repair;
        n_md_start  = 1'b0;
        n_mul_only  = r_mul_only;
        n_mag_a     = r_mag_a;
        n_mag_b     = r_mag_b;
        n_div       = r_div;
        n_res       = r_res;
        n_sat       = r_sat;
        n_zspan     = r_zspan;
        n_oot       = r_oot;

        // Configuration writes land only while the block is idle
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (mmn_pkg::t_cfg_reg'(i_cfg_index))
                mmn_pkg::REG_TARGET_LOW:  n_tlow  = i_cfg_data;
                mmn_pkg::REG_TARGET_HIGH: n_thigh = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            mmn_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_req     = mmn_pkg::t_req'(s_axis_tuser);
                    n_val     = s_axis_tdata[DW-1:0];
                    n_valh    = s_axis_tdata[2*DW-1:DW];
                    n_restart = s_axis_tdata[2*DW];
                    n_last    = s_axis_tlast;
                    n_state   = mmn_pkg::ST_DIFF;
                end
            end
            mmn_pkg::ST_DIFF: begin
                n_res    = '0;
                n_sat    = 1'b0;
                n_zspan  = 1'b0;
                n_oot    = 1'b0;
                n_repair = 1'b0;
                unique case (r_req)
                    mmn_pkg::REQ_OBSERVE: begin
                        // Restart or widen the tracked bounds
                        if (r_restart) begin
                            n_seen_low  = r_val;
                            n_seen_high = r_val;
                        end else begin
                            if (r_val > r_seen_high) n_seen_high = r_val;
                            if (r_val < r_seen_low)  n_seen_low  = r_val;
                        end
                        n_state = mmn_pkg::ST_REPAIR;
                    end
                    mmn_pkg::REQ_FORWARD: begin
                        n_a     = mmn_pkg::SPAN_W'(r_val) - mmn_pkg::SPAN_W'(r_seen_low);
                        n_b     = mmn_pkg::SPAN_W'(r_thigh) - mmn_pkg::SPAN_W'(r_tlow);
                        n_span  = mmn_pkg::SPAN_W'(r_seen_high)
                                  - mmn_pkg::SPAN_W'(r_seen_low);
                        n_off   = mmn_pkg::OFF_W'(r_tlow);
                        n_state = mmn_pkg::ST_LAUNCH;
                    end
                    mmn_pkg::REQ_MAPBACK: begin
                        n_a     = mmn_pkg::SPAN_W'(r_val) - mmn_pkg::SPAN_W'(r_tlow);
                        n_b     = mmn_pkg::SPAN_W'(r_seen_high)
                                  - mmn_pkg::SPAN_W'(r_seen_low);
                        n_span  = mmn_pkg::SPAN_W'(r_thigh) - mmn_pkg::SPAN_W'(r_tlow);
                        n_off   = mmn_pkg::OFF_W'(r_seen_low);
                        n_state = mmn_pkg::ST_LAUNCH;
                    end
                    mmn_pkg::REQ_LOAD: begin
                        n_seen_low  = r_val;
                        n_seen_high = r_valh;
                        n_state     = mmn_pkg::ST_OUT;
                    end
                    default: begin
                        n_state = mmn_pkg::ST_OUT;
                    end
                endcase
            end
            mmn_pkg::ST_LAUNCH: begin
                // Zero or negative span skips the divide
                if (r_span[mmn_pkg::SPAN_W-1] || (r_span == '0)) begin
                    n_zspan = 1'b1;
                    n_res   = r_off[DW-1:0];
                    n_state = mmn_pkg::ST_RANGE;
                end else begin
                    n_md_start = 1'b1;
                    n_mul_only = 1'b0;
                    n_mag_a    = a_abs[DW-1:0];
                    n_mag_b    = b_abs[DW-1:0];
                    n_div      = r_span[DW-1:0];
                    n_neg      = r_a[mmn_pkg::SPAN_W-1] ^ r_b[mmn_pkg::SPAN_W-1];
                    n_state    = mmn_pkg::ST_WAIT;
                end
            end
            mmn_pkg::ST_REPAIR: begin
                // Equal bounds at batch end: high = h + h*h/2^16 + 1.0
                if (r_last && (r_seen_low == r_seen_high)) begin
                    n_md_start = 1'b1;
                    n_mul_only = 1'b1;
                    n_mag_a    = h_abs[DW-1:0];
                    n_mag_b    = h_abs[DW-1:0];
                    n_div      = r_div;
                    n_off      = mmn_pkg::OFF_W'(r_seen_high) + mmn_pkg::Q_ONE_OFF;
                    n_repair   = 1'b1;
                    n_state    = mmn_pkg::ST_WAIT;
                end else begin
                    n_state = mmn_pkg::ST_OUT;
                end
            end
            mmn_pkg::ST_WAIT: begin
                if (md_sts.done) begin
                    if (r_repair) begin
                        n_acc = $signed({1'b0,
                                md_sts.prod[mmn_pkg::PROD_W-1:mmn_pkg::FRAC_W]});
                    end else begin
                        n_acc = r_neg ? -q_ext : q_ext;
                    end
                    n_state = mmn_pkg::ST_SUM;
                end
            end
            mmn_pkg::ST_SUM: begin
                n_sat = sum_pos_ovf || sum_neg_ovf;
                if (r_repair) begin
                    n_seen_high = sum_sat;
                    n_state     = mmn_pkg::ST_OUT;
                end else begin
                    n_res   = sum_sat;
                    n_state = mmn_pkg::ST_RANGE;
                end
            end
            mmn_pkg::ST_RANGE: begin
                // Flag forward results outside the target range
                if (r_req == mmn_pkg::REQ_FORWARD) begin
                    n_oot = (r_res < r_tlow) || (r_res > r_thigh);
                end
                n_state = mmn_pkg::ST_OUT;
            end
            mmn_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = mmn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mmn_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and tracked bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmn_pkg::ST_IDLE;
            r_tlow      <= mmn_pkg::TARGET_LOW_RST;
            r_thigh     <= mmn_pkg::TARGET_HIGH_RST;
            r_seen_low  <= mmn_pkg::SEEN_LOW_RST;
            r_seen_high <= mmn_pkg::SEEN_HIGH_RST;
            r_md_start  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tlow      <= n_tlow;
            r_thigh     <= n_thigh;
            r_seen_low  <= n_seen_low;
            r_seen_high <= n_seen_high;
            r_md_start  <= n_md_start;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_val      <= n_val;
        r_valh     <= n_valh;
        r_restart  <= n_restart;
        r_last     <= n_last;
        r_a        <= n_a;
        r_b        <= n_b;
        r_span     <= n_span;
        r_off      <= n_off;
        r_acc      <= n_acc;
        r_neg      <= n_neg;
        r_repair   <= n_repair;
        r_mul_only <= n_mul_only;
        r_mag_a    <= n_mag_a;
        r_mag_b    <= n_mag_b;
        r_div      <= n_div;
        r_res      <= n_res;
        r_sat      <= n_sat;
        r_zspan    <= n_zspan;
        r_oot      <= n_oot;
    end

endmodule

### src/mmn_checker.sv
// ----------------------------------------------------------------------------
// mmn_checker: port-level checks of the min-max normalizer
// Watches the stream ports and flags ordering and result-flag slips.
// ----------------------------------------------------------------------------
module mmn_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [mmn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [mmn_pkg::DATA_W-1:0]    i_cfg_data,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mmn_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [mmn_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mmn_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // One item in flight: no new input transfer right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // A pending result blocks the input side
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while a result waits");

    // A stalled result holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed under stall");

    // A zero span never divides, so it cannot saturate
    a_zspan_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[33] && m_axis_tdata[32]))
        else $error("zero_span and saturated both set");

endmodule

bind min_max_normalizer_core mmn_checker u_mmn_checker (.*);
